FILE: hdl/sss_pkg.sv
package sss_pkg;

    localparam int unsigned SymW     = 5;
    localparam int unsigned WordW    = 16;
    localparam int unsigned PeriodW  = 16;
    localparam int unsigned PatternW = 40;
    localparam int unsigned PatIdxW  = 3;
    localparam int unsigned CountW   = 5;

    localparam logic [PeriodW-1:0]  RstPeriod  = 16'd500;
    // entries 0..7: 8, A, b, C, d, E, dash, blank
    localparam logic [PatternW-1:0] RstPattern = 40'd595371405672;

    localparam logic [7:0] SegBlank = 8'hFF;

    // register index decoded from paddr[3]
    localparam logic RegPeriod  = 1'b0;
    localparam logic RegPattern = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
    } t_ser_ctl;

    typedef struct packed {
        logic            write;
        logic            scroll;
        logic [SymW-1:0] wdata;
    } t_sym_ctl;

    // active-low segment code, blank above the table
    function automatic logic [7:0] seg_lookup(input logic [SymW-1:0] sym);
        logic [7:0] seg;
        unique case (sym)
            5'd0:    seg = 8'hC0;
            5'd1:    seg = 8'hF9;
            5'd2:    seg = 8'hA4;
            5'd3:    seg = 8'hB0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hF8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'hBF;
            5'd11:   seg = 8'h88;
            5'd12:   seg = 8'h83;
            5'd13:   seg = 8'hC6;
            5'd14:   seg = 8'hA1;
            5'd15:   seg = 8'h86;
            5'd16:   seg = 8'h8E;
            default: seg = SegBlank;
        endcase
        return seg;
    endfunction

endpackage

FILE: hdl/sss_bit_cell.sv
module sss_bit_cell
    import sss_pkg::*;
(
    input  logic     i_clk,
    input  t_ser_ctl i_ctl,
    input  logic     i_par,
    input  logic     i_prev,
    output logic     o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bit <= i_par;
        end else if (i_ctl.shift) begin
            r_bit <= i_prev;
        end
    end

    assign o_bit = r_bit;

endmodule

FILE: hdl/sss_sym_cell.sv
module sss_sym_cell
    import sss_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [SymW-1:0] i_rst_value,
    input  t_sym_ctl        i_ctl,
    input  logic [SymW-1:0] i_next,
    output logic [SymW-1:0] o_sym
);

    logic [SymW-1:0] r_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= i_rst_value;
        end else begin
            priority if (i_ctl.write) begin
                r_sym <= i_ctl.wdata;
            end else if (i_ctl.scroll) begin
                r_sym <= i_next;
            end
        end
    end

    assign o_sym = r_sym;

endmodule

FILE: hdl/seven_segment_scan_serializer_top.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+------------------------------------------
// in       | to block  | i_in_valid / o_in_ready   | i_func i_position i_symbol i_scroll_enable
// out      | from blk  | o_out_valid / i_out_ready | o_serial_bit o_latch_after o_scan_digit
// config   | to block  | psel penable pwrite       | paddr pwdata prdata pready (64-bit APB)
//
// A scan tick yields 16 bits out of a 16-cell shift chain, one per cycle while i_out_ready is high.
// The next tick loads in the cycle the sixteenth bit leaves, so ticks run back to back.
// Symbol writes produce no output and are always accepted, even while bits drain.
// Output stalls freeze the chain; a tick waits until its bits can be loaded.
// Synchronous active-low reset loads the store with the default pattern, period 500.
module seven_segment_scan_serializer_top
    import sss_pkg::*;
#(
    parameter int unsigned DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [2:0]  i_position,
    input  logic [4:0]  i_symbol,
    input  logic        i_scroll_enable,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_serial_bit,
    output logic        o_latch_after,
    output logic [2:0]  o_scan_digit,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned PosW = $clog2(DIGITS);

    logic [PeriodW-1:0]  r_period;
    logic [PatternW-1:0] r_pattern;
    logic [PosW-1:0]     r_scan_pos;
    logic [PosW-1:0]     n_scan_pos;
    logic [PeriodW-1:0]  r_tick;
    logic [PeriodW-1:0]  n_tick;
    logic [PatIdxW-1:0]  r_pat_idx;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   n_count;
    logic [2:0]          r_digit;

    logic                load_ok;
    logic                acc;
    logic                tick_acc;
    logic                wr_acc;
    logic                out_shift;
    logic                cfg_wr;
    logic                hit;
    logic                scroll;
    logic [SymW-1:0]     pat_entry;
    logic [SymW-1:0]     cur_sym;
    logic [WordW-1:0]    word;
    logic [WordW-1:0]    bits;
    logic [SymW-1:0]     w_store [DIGITS];
    t_ser_ctl            ser_ctl;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= RstPeriod;
            r_pattern <= RstPattern;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                RegPeriod:  r_period  <= pwdata[PeriodW-1:0];
                RegPattern: r_pattern <= pwdata[PatternW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            RegPeriod:  prdata = {{(64-PeriodW){1'b0}}, r_period};
            RegPattern: prdata = {{(64-PatternW){1'b0}}, r_pattern};
            default:    prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign load_ok    = (r_count == '0) || ((r_count == CountW'(1)) && i_out_ready);
    assign o_in_ready = i_func | load_ok;
    assign acc        = i_in_valid & o_in_ready;
    assign tick_acc   = acc & ~i_func;
    assign wr_acc     = acc & i_func;

    assign o_out_valid = (r_count != '0);
    assign out_shift   = o_out_valid & i_out_ready;

    // ---------------- scan, tick and scroll control ----------------
    assign n_scan_pos = (r_scan_pos == PosW'(DIGITS - 1)) ? '0 : r_scan_pos + PosW'(1);
    assign n_tick     = r_tick + PeriodW'(1);
    assign hit        = (n_tick >= r_period);
    assign scroll     = tick_acc & hit & i_scroll_enable;
    assign pat_entry  = r_pattern[r_pat_idx*SymW +: SymW];

    always_comb begin
        n_count = r_count;
        if (tick_acc) begin
            n_count = CountW'(WordW);
        end else if (out_shift) begin
            n_count = r_count - CountW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
            r_tick     <= '0;
            r_pat_idx  <= '0;
            r_count    <= '0;
        end else begin
            r_count <= n_count;
            if (tick_acc) begin
                r_scan_pos <= n_scan_pos;
                r_tick     <= hit ? '0 : n_tick;
            end
            if (scroll) begin
                r_pat_idx <= r_pat_idx + PatIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_digit <= 3'(r_scan_pos);
        end
    end

    // ---------------- symbol store: a row of cells shifting left ----------------
    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++) begin : g_sym
            t_sym_ctl        ctl;
            logic [SymW-1:0] nxt;

            assign ctl.write  = wr_acc && (i_position == 3'(gi));
            assign ctl.scroll = scroll;
            assign ctl.wdata  = i_symbol;

            if (gi == DIGITS - 1) begin : g_last
                assign nxt = pat_entry;
            end else begin : g_mid
                assign nxt = w_store[gi+1];
            end

            sss_sym_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_rst_value (RstPattern[gi*SymW +: SymW]),
                .i_ctl       (ctl),
                .i_next      (nxt),
                .o_sym       (w_store[gi])
            );
        end
    endgenerate

    // ---------------- serializer: 16 bit cells, MSB leaves first ----------------
    assign cur_sym = w_store[r_scan_pos];
    assign word    = {~(8'b1 << r_scan_pos), seg_lookup(cur_sym)};

    assign ser_ctl.load  = tick_acc;
    assign ser_ctl.shift = out_shift;

    generate
        for (gi = 0; gi < WordW; gi++) begin : g_bit
            logic prev;

            if (gi == 0) begin : g_first
                assign prev = 1'b0;
            end else begin : g_rest
                assign prev = bits[gi-1];
            end

            sss_bit_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ser_ctl),
                .i_par  (word[gi]),
                .i_prev (prev),
                .o_bit  (bits[gi])
            );
        end
    endgenerate

    assign o_serial_bit  = bits[WordW-1];
    assign o_latch_after = (r_count == CountW'(1));
    assign o_scan_digit  = r_digit;

`ifndef SYNTHESIS
    a_tick_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |-> (r_count == '0) || ((r_count == CountW'(1)) && i_out_ready))
        else $error("tick request loaded over undelivered bits");

    a_run_follows_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (o_out_valid && (r_count == CountW'(WordW))))
        else $error("tick request did not start a 16-bit run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(WordW))
        else $error("bit count out of range");

    a_scan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_pos <= PosW'(DIGITS - 1))
        else $error("scan position beyond last digit");
`endif

endmodule

FILE: test/seven_segment_scan_serializer_top_tb.sv
`timescale 1ns / 1ps

module seven_segment_scan_serializer_top_tb;
    import sss_pkg::*;

    localparam int unsigned Digits    = 8;
    localparam int unsigned IdleLimit = 1000;
    localparam int unsigned DrainWait = 4;

    localparam logic FuncTick  = 1'b0;
    localparam logic FuncWrite = 1'b1;

    // active-low segment codes, entry 0 in the low byte
    localparam logic [18*8-1:0] SegTable = {
        8'hFF, 8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'hBF, 8'h90,
        8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    typedef struct packed {
        logic       serial;
        logic       latch;
        logic [2:0] digit;
    } t_scan_bit;

    class seg_scan_scoreboard;
        logic [PeriodW-1:0]  period;
        logic [PatternW-1:0] pattern;
        logic [2:0]          scan_pos;
        logic [15:0]         tick_cnt;
        logic [2:0]          pat_idx;
        logic [SymW-1:0]     store [8];
        t_scan_bit           expected_bits [$];
        int                  errors;

        function new();
            period   = RstPeriod;
            pattern  = RstPattern;
            scan_pos = '0;
            tick_cnt = '0;
            pat_idx  = '0;
            errors   = 0;
            for (int i = 0; i < 8; i++) store[i] = pattern[i*5 +: 5];
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void set_register(logic idx, logic [63:0] value);
            if (idx == RegPeriod) period = value[PeriodW-1:0];
            else pattern = value[PatternW-1:0];
        endfunction

        function void scroll_store();
            for (int i = 0; i < Digits - 1; i++) store[i] = store[i+1];
            store[Digits-1] = pattern[pat_idx*5 +: 5];
            pat_idx = pat_idx + 3'd1;
        endfunction

        function void predict_scan_bits(logic func, logic [2:0] pos, logic [4:0] sym,
                                        logic en);
            logic [2:0]  cur;
            logic [7:0]  seg;
            logic [15:0] word;
            t_scan_bit   b;
            int          idx;
            if (func == FuncWrite) begin
                if (pos < Digits) store[pos] = sym;
                return;
            end
            cur = scan_pos;
            idx = store[cur];
            seg = (idx < 18) ? SegTable[idx*8 +: 8] : 8'hFF;
            word = {~(8'h01 << cur), seg};
            for (int k = 0; k < 16; k++) begin
                b.serial = word[15-k];
                b.latch  = (k == 15);
                b.digit  = cur;
                expected_bits.push_back(b);
            end
            scan_pos = (cur == Digits - 1) ? 3'd0 : cur + 3'd1;
            tick_cnt = tick_cnt + 16'd1;
            // counter clears on reaching the period even with scrolling off
            if (tick_cnt >= period) begin
                tick_cnt = '0;
                if (en) scroll_store();
            end
        endfunction

        task check_scan_bit(logic serial, logic latch, logic [2:0] digit);
            t_scan_bit e;
            if (expected_bits.size() == 0) begin
                report($sformatf("unexpected bit %b latch %b digit %0d", serial, latch, digit));
                return;
            end
            e = expected_bits.pop_front();
            if (serial !== e.serial)
                report($sformatf("serial_bit got %b exp %b (digit %0d)", serial, e.serial,
                                 e.digit));
            if (latch !== e.latch)
                report($sformatf("latch_after got %b exp %b (digit %0d)", latch, e.latch,
                                 e.digit));
            if (digit !== e.digit)
                report($sformatf("scan_digit got %0d exp %0d", digit, e.digit));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = 1'b0;
    logic [2:0]  i_position = '0;
    logic [4:0]  i_symbol = '0;
    logic        i_scroll_enable = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_serial_bit;
    logic        o_latch_after;
    logic [2:0]  o_scan_digit;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    seg_scan_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    seven_segment_scan_serializer_top #(.DIGITS(Digits)) dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_scan_bit(o_serial_bit, o_latch_after, o_scan_digit);
            if (i_in_valid && o_in_ready)
                sb.predict_scan_bits(i_func, i_position, i_symbol, i_scroll_enable);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAIL seven_segment_scan_serializer_top");
            $finish;
        end
    end

    // result side: random stall before each bit, with calm stretches
    initial begin
        int unsigned gap;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 11);
            repeat (gap) @(negedge i_clk) i_out_ready <= 1'b0;
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task send_request(logic func, logic [2:0] pos, logic [4:0] sym, logic en);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_func          <= func;
        i_position      <= pos;
        i_symbol        <= sym;
        i_scroll_enable <= en;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task random_request();
        logic func;
        func = ($urandom_range(0, 9) < 3) ? FuncWrite : FuncTick;
        send_request(func, 3'($urandom), 5'($urandom), ($urandom_range(0, 4) != 0));
    endtask

    task wait_drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.expected_bits.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    // write, then read back
    task write_register(logic idx, logic [63:0] value);
        logic [63:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        if (pready) sb.set_register(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk) rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == RegPeriod && rd[PeriodW-1:0] !== value[PeriodW-1:0])
            sb.report($sformatf("scroll_period read %0h exp %0h", rd[PeriodW-1:0],
                                value[PeriodW-1:0]));
        if (idx == RegPattern && rd[PatternW-1:0] !== value[PatternW-1:0])
            sb.report($sformatf("scroll_pattern read %0h exp %0h", rd[PatternW-1:0],
                                value[PatternW-1:0]));
    endtask

    initial begin
        logic [4:0]          dir_syms [12];
        logic [PeriodW-1:0]  period;
        logic [PatternW-1:0] pattern;
        dir_syms = '{5'd0, 5'd17, 5'd31, 5'd10, 5'd16, 5'd9, 5'd18, 5'd11,
                     5'd8, 5'd1, 5'd15, 5'd30};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents of the store on the first digits
        send_request(FuncTick, 3'd0, 5'd0, 1'b0);
        send_request(FuncTick, 3'd7, 5'd31, 1'b1);
        // each write lands on the digit the next tick scans
        for (int i = 0; i < 12; i++) begin
            send_request(FuncWrite, 3'((i + 2) % 8), dir_syms[i], i[0]);
            send_request(FuncTick, 3'd0, 5'd0, i[1]);
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_drain();
            pattern = {8'($urandom), 32'($urandom)};
            case (phase)
                0: begin period = 16'd1; pattern = '1; end
                1: begin period = 16'd0; pattern = '0; end
                2: period = 16'hFFFF;
                3: period = 16'd200;
                4: period = 16'd2;                   // drops below the running count
                5: begin period = 16'd3; pattern = RstPattern; end
                default: period = 16'($urandom_range(1, 8));
            endcase
            write_register(RegPeriod, 64'(period));
            write_register(RegPattern, 64'(pattern));
            tx_calm = (phase % 3 == 1);
            for (int i = 0; i < 16; i++) begin
                if (phase == 2 && i == 10) wait_drain();
                random_request();
            end
        end

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.expected_bits.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.expected_bits.size() != 0)
            sb.report($sformatf("%0d bits never arrived", sb.expected_bits.size()));
        if (sb.errors == 0)
            $display("PASS seven_segment_scan_serializer_top");
        else
            $display("FAIL seven_segment_scan_serializer_top");
        $finish;
    end

endmodule
